// ----- hdl/phase_angle_dimmer_with_serial_setpoint_top_macros.svh -----
// Assertion macros shared by the dimmer RTL.
`ifndef PHASE_ANGLE_DIMMER_WITH_SERIAL_SETPOINT_TOP_MACROS_SVH
`define PHASE_ANGLE_DIMMER_WITH_SERIAL_SETPOINT_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PAD_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PAD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pad_pkg.sv -----
// Types and constants of the phase-angle dimmer.
package pad_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_BYTE = 2'd0;
    localparam kind_t KIND_ZC   = 2'd1;
    localparam kind_t KIND_TICK = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [6:0] PCT_FULL   = 7'd100;
    localparam logic [6:0] PCT_SAT    = 7'd101;
    localparam logic [6:0] PCT_ONE    = 7'd1;
    localparam logic [6:0] PCT_MIN    = 7'd2;

    localparam logic [15:0] RESET_HALF_PERIOD = 16'd8333;
    localparam logic [15:0] RESET_DELAY       = 16'd9999;
    localparam logic [15:0] DELAY_MARGIN      = 16'd100;

    // Product of percent (7 bits) and half period (16 bits).
    localparam int PROD_W = 23;
    // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2**23.
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam int RECIP_SHIFT = 30;
    localparam int FULL_W = PROD_W + RECIP_W;

    // APB register map.
    localparam int ADDR_W = 3;
    localparam logic REG_HALF_PERIOD = 1'b0;

    typedef struct packed {
        kind_t       kind;
        logic        echo;
        logic [7:0]  echo_byte;
        logic        setp;
        logic [6:0]  percent;
        logic [15:0] half_period;
        logic [PROD_W-1:0] prod;
    } s1_t;

    typedef struct packed {
        kind_t       kind;
        logic        echo;
        logic [7:0]  echo_byte;
        logic        setp;
        logic [6:0]  percent;
        logic [15:0] half_period;
        logic [15:0] quot;
    } s2_t;

endpackage

// ----- hdl/pad_if.sv -----
// Item and result channel interfaces of the phase-angle dimmer.
interface pad_item_if;
    import pad_pkg::*;

    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] rx_byte;

    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface pad_result_if;
    logic        valid;
    logic        ready;
    logic        ssr_on;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        setpoint_valid;
    logic [6:0]  percent;
    logic [15:0] delay_us;
    logic        fired;

    modport source (output valid, ssr_on, echo_valid, echo_byte, setpoint_valid, percent,
                    delay_us, fired, input ready);
    modport sink   (input valid, ssr_on, echo_valid, echo_byte, setpoint_valid, percent,
                    delay_us, fired, output ready);
endinterface

// ----- hdl/phase_angle_dimmer_with_serial_setpoint_top.sv -----
// Phase-angle dimmer: serial setpoint parser, delay computation and relay one-shot.
//
// Usage: item_in carries one event per transaction: a serial byte (kind 0), a mains
// zero crossing (kind 1) or a one-microsecond tick (kind 2). Every accepted item
// yields exactly one transaction on result_out with the relay level, the digit echo,
// the setpoint flag, the current percent and delay, and the fired flag.
// Digits are kept as a stack of running decimal values, so CR or LF only needs the
// top of the stack; the firing delay is then computed over two pipeline stages
// (percent times half period, then division by 100 through a reciprocal multiply).
// Relay and one-shot state live in the last stage, so items are handled in order.
// Items pass the s1, s2 and output registers; one is accepted every cycle unless
// the pipeline is full. When result_out stalls, the output register holds and the two
// inner stages keep filling; item_in.ready drops only once all three stages are full.
// The APB port holds half_period_us at address 0; pready is always high.
// Reset clears the digit count, percent, relay and one-shot, and loads the delay
// with 9999 and the half period with 8333. The digit stack itself is not cleared.
module phase_angle_dimmer_with_serial_setpoint_top #(
    parameter int MAX_DIGITS = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pad_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    pad_item_if.sink                   item_in,
    pad_result_if.source               result_out
);
    import pad_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    // Configuration register.
    logic [15:0] half_period_reg;
    logic        cfg_write;

    // Digit stack.
    logic [6:0]       prefix_mem [MAX_DIGITS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] next_m1;
    logic [6:0]       top_reg;
    logic [6:0]       prev_val;
    logic [10:0]      grown;
    logic [6:0]       pushed_val;
    logic             push_en;
    logic [3:0]       digit;
    logic [6:0]       line_pct;

    // Pipeline.
    logic accept;
    logic out_free, s2_free, s1_free;
    logic s1_adv, s2_adv;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg;
    logic [FULL_W-1:0] full_prod;

    // Final stage state.
    logic [6:0]  percent_reg, percent_next;
    logic [15:0] delay_reg, delay_next;
    logic        running_reg, running_next;
    logic [15:0] shot_count_reg, shot_count_next;
    logic [15:0] reload_reg, reload_next;
    logic        relay_reg, relay_next;
    logic        fired_reg, fired_next;
    logic [15:0] line_delay;
    logic [15:0] diff;

    // Output register.
    logic        out_echo_reg;
    logic [7:0]  out_echo_byte_reg;
    logic        out_setp_reg;

    // ------------------------------------------------------------------ APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_HALF_PERIOD);

    always_comb
    begin
        if (paddr[2] == REG_HALF_PERIOD)
        begin
            prdata = {16'd0, half_period_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= RESET_HALF_PERIOD;
        end
        else if (cfg_write)
        begin
            half_period_reg <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------ handshake
    assign out_free      = !out_valid_reg || result_out.ready;
    assign s2_adv        = s2_valid_reg && out_free;
    assign s2_free       = !s2_valid_reg || out_free;
    assign s1_adv        = s1_valid_reg && s2_free;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign item_in.ready = s1_free;
    assign accept        = item_in.valid && s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------- digit stack and line
    // Each entry holds the saturated value of the digits up to and including it,
    // so backspace is just a pop and a line end reads the top entry.
    assign count_m1 = count_reg - CNT_W'(1);
    assign next_m1  = count_next - CNT_W'(1);
    assign digit    = 4'(item_in.rx_byte - CHAR_ZERO);

    always_comb
    begin
        if (count_reg == '0)
        begin
            prev_val = 7'd0;
        end
        else
        begin
            prev_val = top_reg;
        end
        grown = {4'd0, prev_val} * 11'd10 + {7'd0, digit};
        if (grown > {4'd0, PCT_FULL})
        begin
            pushed_val = PCT_SAT;
        end
        else
        begin
            pushed_val = grown[6:0];
        end
        if (prev_val > PCT_FULL)
        begin
            line_pct = PCT_FULL;
        end
        else if (prev_val == PCT_ONE)
        begin
            line_pct = PCT_MIN;
        end
        else
        begin
            line_pct = prev_val;
        end
    end

    always_comb
    begin
        count_next        = count_reg;
        push_en           = 1'b0;
        s1_next           = '0;
        s1_next.kind      = item_in.kind;
        s1_next.percent   = line_pct;
        s1_next.half_period = half_period_reg;
        s1_next.prod      = PROD_W'(line_pct) * PROD_W'(half_period_reg);
        if (item_in.kind == KIND_BYTE)
        begin
            if (item_in.rx_byte == CHAR_CR || item_in.rx_byte == CHAR_LF)
            begin
                if (count_reg != '0)
                begin
                    s1_next.setp = 1'b1;
                    count_next   = '0;
                end
            end
            else if (item_in.rx_byte == CHAR_BS || item_in.rx_byte == CHAR_DEL)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_m1;
                end
            end
            else if (item_in.rx_byte >= CHAR_ZERO && item_in.rx_byte <= CHAR_NINE)
            begin
                if (count_reg < CNT_W'(MAX_DIGITS))
                begin
                    push_en           = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                    s1_next.echo      = 1'b1;
                    s1_next.echo_byte = item_in.rx_byte;
                end
            end
        end
    end

    // The top entry is kept in a register; a pop reloads it from the entry below.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (push_en)
            begin
                prefix_mem[count_reg[IDX_W-1:0]] <= pushed_val;
                top_reg                          <= pushed_val;
            end
            else if (count_next != '0)
            begin
                top_reg <= prefix_mem[next_m1[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------- divide by 100 stage
    assign full_prod = FULL_W'(s1_reg.prod) * FULL_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_reg.kind        <= s1_reg.kind;
            s2_reg.echo        <= s1_reg.echo;
            s2_reg.echo_byte   <= s1_reg.echo_byte;
            s2_reg.setp        <= s1_reg.setp;
            s2_reg.percent     <= s1_reg.percent;
            s2_reg.half_period <= s1_reg.half_period;
            s2_reg.quot        <= full_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        end
    end

    // ------------------------------------------------ delay and relay stage
    always_comb
    begin
        diff = s2_reg.half_period - s2_reg.quot;
        if (s2_reg.percent == 7'd0)
        begin
            line_delay = s2_reg.half_period;
        end
        else if (s2_reg.percent == PCT_FULL)
        begin
            line_delay = 16'd0;
        end
        else
        begin
            // A zero quotient would leave the full half period; back off instead.
            if (s2_reg.quot == 16'd0)
            begin
                line_delay = (s2_reg.half_period >= DELAY_MARGIN) ?
                             s2_reg.half_period - DELAY_MARGIN : 16'd0;
            end
            else
            begin
                line_delay = diff;
            end
            if (line_delay == 16'd0)
            begin
                line_delay = 16'd1;
            end
        end
    end

    always_comb
    begin
        percent_next    = percent_reg;
        delay_next      = delay_reg;
        running_next    = running_reg;
        shot_count_next = shot_count_reg;
        reload_next     = reload_reg;
        relay_next      = relay_reg;
        fired_next      = fired_reg;
        if (s2_reg.setp)
        begin
            percent_next = s2_reg.percent;
            delay_next   = line_delay;
        end
        case (s2_reg.kind)
            KIND_ZC:
            begin
                fired_next = 1'b0;
                if (percent_reg < PCT_FULL)
                begin
                    relay_next = 1'b0;
                    if (percent_reg != 7'd0)
                    begin
                        shot_count_next = 16'd0;
                        reload_next     = delay_reg;
                        running_next    = 1'b1;
                    end
                end
                else
                begin
                    relay_next = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if (running_reg)
                begin
                    if (shot_count_reg >= reload_reg)
                    begin
                        relay_next      = 1'b1;
                        fired_next      = 1'b1;
                        running_next    = 1'b0;
                        shot_count_next = 16'd0;
                    end
                    else
                    begin
                        shot_count_next = shot_count_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                percent_next = percent_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            percent_reg    <= 7'd0;
            delay_reg      <= RESET_DELAY;
            running_reg    <= 1'b0;
            shot_count_reg <= 16'd0;
            reload_reg     <= 16'd0;
            relay_reg      <= 1'b0;
            fired_reg      <= 1'b0;
        end
        else if (s2_adv)
        begin
            percent_reg    <= percent_next;
            delay_reg      <= delay_next;
            running_reg    <= running_next;
            shot_count_reg <= shot_count_next;
            reload_reg     <= reload_next;
            relay_reg      <= relay_next;
            fired_reg      <= fired_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_echo_reg      <= s2_reg.echo;
            out_echo_byte_reg <= s2_reg.echo_byte;
            out_setp_reg      <= s2_reg.setp;
        end
    end

    // The persistent fields of the result are the stage state itself.
    assign result_out.valid          = out_valid_reg;
    assign result_out.ssr_on         = relay_reg;
    assign result_out.echo_valid     = out_echo_reg;
    assign result_out.echo_byte      = out_echo_byte_reg;
    assign result_out.setpoint_valid = out_setp_reg;
    assign result_out.percent        = percent_reg;
    assign result_out.delay_us       = delay_reg;
    assign result_out.fired          = fired_reg;

    // ------------------------------------------------------------ checks
`include "phase_angle_dimmer_with_serial_setpoint_top_macros.svh"

    `PAD_ASSERT_NOW(a_fired_relay_on, clk, rst_n, fired_reg, relay_reg,
        "fired flag set while relay is off")
    `PAD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_DIGITS),
        "digit count beyond capacity")
    `PAD_ASSERT_NOW(a_shot_bound, clk, rst_n, running_reg, shot_count_reg <= reload_reg,
        "one-shot count passed its reload")
    `PAD_ASSERT_NOW(a_echo_digit, clk, rst_n, out_valid_reg && out_echo_reg,
        out_echo_byte_reg >= CHAR_ZERO && out_echo_byte_reg <= CHAR_NINE,
        "echo of a non-digit character")
    `PAD_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, s1_valid_reg,
        "accepted transaction did not enter the pipeline")

endmodule

// ----- dv/pad_scoreboard.sv -----
// Scoreboard of the phase-angle dimmer: predicts every result and compares it field by field.
`timescale 1ns / 100ps
module pad_scoreboard #(
    parameter int MAX_DIGITS = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pad_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    pad_item_if                        item_mon,
    pad_result_if                      result_mon,
    output int                         fail_count,
    output int                         pending
);
    import pad_pkg::*;

    localparam logic [ADDR_W-1:0] HP_ADDR = ADDR_W'(4 * int'(REG_HALF_PERIOD));

    typedef struct packed {
        logic        ssr_on;
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic        setpoint_valid;
        logic [6:0]  percent;
        logic [15:0] delay_us;
        logic        fired;
    } dimmer_out_t;

    logic [15:0] half_period;
    logic [3:0]  digits [MAX_DIGITS];
    int unsigned n_digits;
    logic [6:0]  percent;
    logic [15:0] fire_delay;
    logic        shot_on;
    logic [15:0] shot_cnt;
    logic [15:0] shot_limit;
    logic        relay;
    logic        fired;
    dimmer_out_t expected_q [$];
    int          errors = 0;

    // Turns the stored digits into a percent and a firing delay.
    function automatic void apply_setpoint();
        int unsigned value;
        int unsigned hp;
        int unsigned d;
        value = 0;
        hp = half_period;
        for (int i = 0; i < n_digits; i++)
        begin
            value = value * 10 + digits[i];
            if (value > PCT_FULL)
                value = PCT_SAT;
        end
        if (value > PCT_FULL)
            value = PCT_FULL;
        if (value == PCT_ONE)
            value = PCT_MIN;
        if (value == 0)
            d = hp;
        else if (value == PCT_FULL)
            d = 0;
        else
        begin
            d = hp - (value * hp) / PCT_FULL;
            if (d >= hp)
                d = (hp >= DELAY_MARGIN) ? hp - DELAY_MARGIN : 0;
            if (d == 0)
                d = 1;
        end
        percent = value[6:0];
        fire_delay = d[15:0];
        n_digits = 0;
    endfunction

    function automatic dimmer_out_t step_dimmer(kind_t kind, logic [7:0] rx);
        dimmer_out_t res;
        res = '0;
        case (kind)
            KIND_BYTE:
            begin
                if (rx == CHAR_CR || rx == CHAR_LF)
                begin
                    if (n_digits > 0)
                    begin
                        apply_setpoint();
                        res.setpoint_valid = 1'b1;
                    end
                end
                else if (rx == CHAR_BS || rx == CHAR_DEL)
                begin
                    if (n_digits > 0)
                        n_digits--;
                end
                else if (rx >= CHAR_ZERO && rx <= CHAR_NINE)
                begin
                    // A digit beyond a full buffer is dropped without an echo.
                    if (n_digits < MAX_DIGITS)
                    begin
                        digits[n_digits] = 4'(rx - CHAR_ZERO);
                        n_digits++;
                        res.echo_valid = 1'b1;
                        res.echo_byte = rx;
                    end
                end
            end
            KIND_ZC:
            begin
                fired = 1'b0;
                if (percent < PCT_FULL)
                begin
                    relay = 1'b0;
                    // At zero percent a running shot is left alone.
                    if (percent != 0)
                    begin
                        shot_cnt = '0;
                        shot_limit = fire_delay;
                        shot_on = 1'b1;
                    end
                end
                else
                    relay = 1'b1;
            end
            KIND_TICK:
            begin
                if (shot_on)
                begin
                    if (shot_cnt >= shot_limit)
                    begin
                        relay = 1'b1;
                        fired = 1'b1;
                        shot_on = 1'b0;
                        shot_cnt = '0;
                    end
                    else
                        shot_cnt = shot_cnt + 16'd1;
                end
            end
            default:
            begin
            end
        endcase
        res.ssr_on = relay;
        res.percent = percent;
        res.delay_us = fire_delay;
        res.fired = fired;
        return res;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dimmer_out_t want;
        if (!rst_n)
        begin
            half_period = RESET_HALF_PERIOD;
            n_digits = 0;
            percent = '0;
            fire_delay = RESET_DELAY;
            shot_on = 1'b0;
            shot_cnt = '0;
            shot_limit = '0;
            relay = 1'b0;
            fired = 1'b0;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == HP_ADDR)
                half_period = pwdata[15:0];
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("ssr_on", want.ssr_on, result_mon.ssr_on);
                    compare_field("echo_valid", want.echo_valid, result_mon.echo_valid);
                    compare_field("echo_byte", want.echo_byte, result_mon.echo_byte);
                    compare_field("setpoint_valid", want.setpoint_valid,
                                  result_mon.setpoint_valid);
                    compare_field("percent", want.percent, result_mon.percent);
                    compare_field("delay_us", want.delay_us, result_mon.delay_us);
                    compare_field("fired", want.fired, result_mon.fired);
                end
            end
            if (item_mon.valid && item_mon.ready)
                expected_q.push_back(step_dimmer(item_mon.kind, item_mon.rx_byte));
        end
        pending <= expected_q.size();
        fail_count <= errors;
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top of the phase-angle dimmer: clock, reset, register writes and item traffic.
`timescale 1ns / 100ps
module tb_top;
    import pad_pkg::*;

    localparam int MAX_DIGITS = 9;
    localparam int LATENCY = 3;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 300000;
    localparam kind_t KIND_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] HP_ADDR = ADDR_W'(4 * int'(REG_HALF_PERIOD));

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              no_idle;
    logic              hold_req;
    logic              hold_done = 1'b0;
    int                hold_left = 0;
    int                items_sent;
    int                cycle_count = 0;
    int                fail_count;
    int                pending;

    pad_item_if   item_if ();
    pad_result_if result_if ();

    phase_angle_dimmer_with_serial_setpoint_top #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_in    (item_if),
        .result_out (result_if)
    );

    pad_scoreboard #(
        .MAX_DIGITS(MAX_DIGITS)
    ) scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .item_mon   (item_if),
        .result_mon (result_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, none while no_idle is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            result_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            result_if.ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
            result_if.ready <= no_idle || ($urandom_range(0, 99) >= 26);
    end

    task automatic send_item(kind_t kind, logic [7:0] rx);
        while (!no_idle && $urandom_range(0, 99) < 26)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.kind <= kind;
        item_if.rx_byte <= rx;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_half_period(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HP_ADDR;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // One typed setpoint line, now and then with a wrong digit taken back.
    task automatic send_line();
        int unsigned value;
        int unsigned pick;
        logic [7:0]  digs [$];
        pick = $urandom_range(0, 99);
        if (pick < 55)
            value = $urandom_range(90, 99);
        else if (pick < 65)
            value = 0;
        else if (pick < 75)
            value = 100;
        else if (pick < 80)
            value = 1;
        else
            value = $urandom_range(0, 999999999);
        do
        begin
            digs.push_front(CHAR_ZERO + 8'(value % 10));
            value = value / 10;
        end
        while (value != 0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) digs.push_front(CHAR_ZERO);
        foreach (digs[i])
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(KIND_BYTE, CHAR_ZERO + 8'($urandom_range(0, 9)));
                send_item(KIND_BYTE, $urandom_range(0, 1) ? CHAR_BS : CHAR_DEL);
            end
            send_item(KIND_BYTE, digs[i]);
        end
        send_item(KIND_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    // Mostly mains half-cycles (a zero crossing and a run of ticks) and setpoint lines.
    task automatic run_traffic(int count, int max_burst);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_line();
            else if (pick < 44)
                send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
            else if (pick < 47)
                send_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
            else if (pick < 50)
                send_item(KIND_BYTE, $urandom_range(0, 1) ? CHAR_BS : CHAR_CR);
            else
            begin
                send_item(KIND_ZC, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, max_burst))
                    send_item(KIND_TICK, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        item_if.valid = 1'b0;
        item_if.kind = KIND_BYTE;
        item_if.rx_byte = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset half period.
        send_item(KIND_UNUSED, 8'hFF);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, CHAR_CR);
        send_item(KIND_BYTE, CHAR_BS);
        // Ten digits: the last one finds the buffer full.
        for (int i = 0; i <= 9; i++)
            send_item(KIND_BYTE, CHAR_ZERO + 8'(i));
        send_item(KIND_BYTE, CHAR_DEL);
        send_item(KIND_BYTE, CHAR_LF);
        send_item(KIND_ZC, 8'h00);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, CHAR_ZERO + 8'd1);
        send_item(KIND_BYTE, CHAR_CR);
        send_item(KIND_ZC, 8'h00);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, CHAR_NINE - 8'd9);
        send_item(KIND_BYTE, CHAR_CR);
        drain();

        write_half_period(16'd1000);
        run_traffic(250, 80);
        hold_req <= 1'b1;
        run_traffic(250, 80);
        drain();

        write_half_period(16'd65535);
        run_traffic(250, 40);
        drain();

        write_half_period(16'($urandom_range(1000, 3000)));
        no_idle <= 1'b1;
        run_traffic(250, 80);
        no_idle <= 1'b0;
        run_traffic(250, 80);
        drain();

        write_half_period(16'($urandom_range(1000, 65535)));
        run_traffic(250, 80);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pad_pkg.sv
hdl/pad_if.sv
hdl/phase_angle_dimmer_with_serial_setpoint_top.sv
dv/pad_scoreboard.sv
dv/tb_top.sv
